// ===== rtl/skc_pkg.sv =====
// ----------------------------------------------------------------------------
// skc_pkg
// Shared types, constants and lookup tables of the soft knee compressor.
// ----------------------------------------------------------------------------
package skc_pkg;

    localparam int SAMPLE_BITS = 24;
    localparam int COEF_BITS   = 24;
    localparam int ENV_W       = 25;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int FIFO_DEPTH  = 2;
    localparam int FIFO_PTR_W  = 1;
    localparam int FIFO_CNT_W  = 2;
    localparam int MUL_A_W     = 30;
    localparam int MUL_B_W     = 24;
    localparam int PROD_W      = MUL_A_W + MUL_B_W;
    localparam int DIV_STEPS   = 17;
    localparam int NORM_STEPS  = 5;

    localparam logic [ENV_W-1:0] ENV_ONE      = 25'h1000000;
    localparam logic [23:0]      DB_PER_LOG2  = 24'd394567;
    localparam logic [23:0]      LOG2_10_DB20 = 24'd10885;

    // register indexes of the config port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DETECT     = 3'd0,
        CFG_ATTACK     = 3'd1,
        CFG_RELEASE    = 3'd2,
        CFG_THRESHOLD  = 3'd3,
        CFG_KNEE       = 3'd4,
        CFG_KNEE_RECIP = 3'd5,
        CFG_RATIO      = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [23:0]        detect_coeff;
        logic [23:0]        attack_coeff;
        logic [23:0]        release_coeff;
        logic signed [15:0] threshold_db;
        logic [12:0]        knee_db;
        logic [23:0]        knee_recip;
        logic [12:0]        ratio;
    } cfg_t;

    // classified sample: sign and magnitude
    typedef struct packed {
        logic                   neg;
        logic [SAMPLE_BITS-1:0] mag;
    } smp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PK,
        ST_PK_UPD,
        ST_SM,
        ST_SM_UPD,
        ST_NORM,
        ST_LOG_INT,
        ST_LOG_NEG,
        ST_LOG_MUL,
        ST_LEVEL,
        ST_T_MUL,
        ST_T_UPD,
        ST_AO,
        ST_AT,
        ST_NUM,
        ST_DIV,
        ST_E_MUL,
        ST_E_UPD,
        ST_G_INT,
        ST_G_UPD,
        ST_Y_MUL,
        ST_OUT
    } state_t;

    // log2(1 + k/16) in Q0.16
    function automatic logic [16:0] log2_lut(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd0;
            5'd1:    v = 17'd5732;
            5'd2:    v = 17'd11136;
            5'd3:    v = 17'd16248;
            5'd4:    v = 17'd21098;
            5'd5:    v = 17'd25711;
            5'd6:    v = 17'd30110;
            5'd7:    v = 17'd34312;
            5'd8:    v = 17'd38336;
            5'd9:    v = 17'd42196;
            5'd10:   v = 17'd45904;
            5'd11:   v = 17'd49472;
            5'd12:   v = 17'd52911;
            5'd13:   v = 17'd56229;
            5'd14:   v = 17'd59434;
            5'd15:   v = 17'd62534;
            5'd16:   v = 17'd65536;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

    // 2^(-k/16) in Q0.16
    function automatic logic [16:0] pow2_lut(input logic [4:0] idx);
        logic [16:0] v;
        case (idx)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/skc_front.sv =====
// ----------------------------------------------------------------------------
// skc_front
// Input side: takes sample beats and splits them into sign and magnitude.
// ----------------------------------------------------------------------------
module skc_front
    import skc_pkg::*;
(
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          push,
    output smp_t                          push_data,
    input  logic                          queue_ready
);

    // accept whenever the queue has room
    assign in_ready = queue_ready;
    assign push     = in_valid & queue_ready;

    // magnitude of the full negative value fits as unsigned
    always_comb
    begin
        push_data.neg = in_sample[SAMPLE_BITS-1];
        if (in_sample[SAMPLE_BITS-1])
        begin
            push_data.mag = SAMPLE_BITS'(-in_sample);
        end
        else
        begin
            push_data.mag = in_sample;
        end
    end

endmodule

// ===== rtl/skc_fifo.sv =====
// ----------------------------------------------------------------------------
// skc_fifo
// Short queue between the classifying front and the compute sequencer.
// ----------------------------------------------------------------------------
module skc_fifo
    import skc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  smp_t push_data,
    output logic push_ready,
    input  logic pop,
    output smp_t pop_data,
    output logic pop_valid
);

    smp_t                  mem_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CNT_W-1:0] count_reg, count_next;
    logic                  do_push, do_pop;

    assign push_ready = (count_reg != FIFO_CNT_W'(FIFO_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push & push_ready;
    assign do_pop     = pop & pop_valid;

    // pointer and fill count
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== rtl/skc_back.sv =====
// ----------------------------------------------------------------------------
// skc_back
// Compute sequencer: envelopes, level in dB, soft knee gain and output scaling
// on one shared multiplier and a bit-serial divider.
// ----------------------------------------------------------------------------
module skc_back
    import skc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          pop_valid,
    input  smp_t                          pop_data,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    state_t state_reg, state_next;

    logic [ENV_W-1:0]   peak_reg, peak_next;
    logic [ENV_W-1:0]   sm_reg, sm_next;
    logic               out_valid_reg, out_valid_next;

    smp_t               smp_reg, smp_next;
    logic               sgn_reg, sgn_next;
    logic [ENV_W-1:0]   x_reg, x_next;
    logic [4:0]         p_reg, p_next;
    logic               zero_reg, zero_next;
    logic [2:0]         step_reg, step_next;
    logic [20:0]        negl_reg, negl_next;
    logic [15:0]        over_reg, over_next;
    logic [16:0]        t_reg, t_next;
    logic [28:0]        ao_reg, ao_next;
    logic [29:0]        den_reg, den_next;
    logic [29:0]        rem_reg, rem_next;
    logic [16:0]        dl_reg, dl_next;
    logic [22:0]        e_reg, e_next;
    logic [16:0]        g_reg, g_next;
    logic [SAMPLE_BITS-1:0] out_reg, out_next;
    logic [PROD_W-1:0]  prod_reg;

    logic [MUL_A_W-1:0] mul_a;
    logic [MUL_B_W-1:0] mul_b;
    logic               mul_en;

    logic [ENV_W-1:0]   env_w;
    logic [12:0]        slope;
    logic               out_free;

    // one pole update, prev - target difference already multiplied by the pole
    function automatic logic [ENV_W-1:0] pole_upd(
        input logic [ENV_W-1:0]  target,
        input logic [PROD_W-1:0] prod,
        input logic              sub
    );
        logic [49:0] sum;
        logic [25:0] res;
        sum = {1'b0, target, 24'b0} + 50'h800000;
        if (sub)
        begin
            sum = sum - prod[49:0];
        end
        else
        begin
            sum = sum + prod[49:0];
        end
        res = sum[49:24];
        if (res > {1'b0, ENV_ONE})
        begin
            res = {1'b0, ENV_ONE};
        end
        return res[ENV_W-1:0];
    endfunction

    assign env_w     = {smp_reg.mag, 1'b0};
    assign slope     = (cfg.ratio < 13'd256) ? 13'd0 : cfg.ratio - 13'd256;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_sample = out_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:    if (pop_valid) state_next = ST_PK;
            ST_PK:      state_next = ST_PK_UPD;
            ST_PK_UPD:  state_next = ST_SM;
            ST_SM:      state_next = ST_SM_UPD;
            ST_SM_UPD:  state_next = ST_NORM;
            ST_NORM:    if (step_reg == 3'(NORM_STEPS - 1)) state_next = ST_LOG_INT;
            ST_LOG_INT: state_next = ST_LOG_NEG;
            ST_LOG_NEG: state_next = ST_LOG_MUL;
            ST_LOG_MUL: state_next = ST_LEVEL;
            ST_LEVEL:   state_next = ST_T_MUL;
            ST_T_MUL:   state_next = ST_T_UPD;
            ST_T_UPD:   state_next = ST_AO;
            ST_AO:      state_next = ST_AT;
            ST_AT:      state_next = ST_NUM;
            ST_NUM:     state_next = ST_DIV;
            ST_DIV:     if (x_reg[4:0] == 5'(DIV_STEPS - 1)) state_next = ST_E_MUL;
            ST_E_MUL:   state_next = ST_E_UPD;
            ST_E_UPD:   state_next = ST_G_INT;
            ST_G_INT:   state_next = ST_G_UPD;
            ST_G_UPD:   state_next = ST_Y_MUL;
            ST_Y_MUL:   state_next = ST_OUT;
            ST_OUT:     if (out_free) state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // outputs of the sequencer: queue pop and multiplier operands
    always_comb
    begin
        pop    = 1'b0;
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (state_reg)
            ST_IDLE:
            begin
                pop    = pop_valid;
                mul_en = 1'b0;
            end
            ST_PK:
            begin
                mul_a = (peak_reg >= env_w) ? MUL_A_W'(peak_reg - env_w)
                                            : MUL_A_W'(env_w - peak_reg);
                mul_b = cfg.detect_coeff;
            end
            ST_SM:
            begin
                mul_a = (sm_reg >= peak_reg) ? MUL_A_W'(sm_reg - peak_reg)
                                             : MUL_A_W'(peak_reg - sm_reg);
                mul_b = (sm_reg < peak_reg) ? cfg.attack_coeff : cfg.release_coeff;
            end
            ST_LOG_INT:
            begin
                mul_a = MUL_A_W'(log2_lut({1'b0, x_reg[23:20]} + 5'd1)
                                 - log2_lut({1'b0, x_reg[23:20]}));
                mul_b = MUL_B_W'(x_reg[19:8]);
            end
            ST_LOG_MUL:
            begin
                mul_a = MUL_A_W'(negl_reg);
                mul_b = DB_PER_LOG2;
            end
            ST_T_MUL:
            begin
                mul_a = MUL_A_W'(over_reg);
                mul_b = cfg.knee_recip;
            end
            ST_T_UPD:
            begin
                mul_a = MUL_A_W'(over_reg);
                mul_b = MUL_B_W'(slope);
            end
            ST_AO:
            begin
                mul_a = MUL_A_W'(t_reg);
                mul_b = MUL_B_W'(slope);
            end
            ST_AT:
            begin
                mul_a = MUL_A_W'(ao_reg);
                mul_b = MUL_B_W'(t_reg);
            end
            ST_E_MUL:
            begin
                mul_a = MUL_A_W'(dl_reg);
                mul_b = LOG2_10_DB20;
            end
            ST_G_INT:
            begin
                mul_a = MUL_A_W'(pow2_lut({1'b0, e_reg[15:12]})
                                 - pow2_lut({1'b0, e_reg[15:12]} + 5'd1));
                mul_b = MUL_B_W'(e_reg[11:0]);
            end
            ST_Y_MUL:
            begin
                mul_a = MUL_A_W'(smp_reg.mag);
                mul_b = MUL_B_W'(g_reg);
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    // datapath
    always_comb
    begin
        logic [16:0] lf;
        logic [40:0] mdb_sum;
        logic [16:0] mdb;
        logic signed [16:0] lvl;
        logic signed [18:0] over_s;
        logic [46:0] n_full;
        logic [30:0] r2;
        logic [31:0] e_sum;
        logic [16:0] g_base;
        logic [40:0] y_sum;
        logic [24:0] y;

        lf      = '0;
        mdb_sum = '0;
        mdb     = '0;
        lvl     = '0;
        over_s  = '0;
        n_full  = '0;
        r2      = '0;
        e_sum   = '0;
        g_base  = '0;
        y_sum   = '0;
        y       = '0;

        peak_next      = peak_reg;
        sm_next        = sm_reg;
        smp_next       = smp_reg;
        sgn_next       = sgn_reg;
        x_next         = x_reg;
        p_next         = p_reg;
        zero_next      = zero_reg;
        step_next      = step_reg;
        negl_next      = negl_reg;
        over_next      = over_reg;
        t_next         = t_reg;
        ao_next        = ao_reg;
        den_next       = den_reg;
        rem_next       = rem_reg;
        dl_next        = dl_reg;
        e_next         = e_reg;
        g_next         = g_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            ST_IDLE:
            begin
                smp_next = pop_data;
            end
            ST_PK:
            begin
                sgn_next = peak_reg < env_w;
            end
            ST_PK_UPD:
            begin
                peak_next = pole_upd(env_w, prod_reg, sgn_reg);
            end
            ST_SM:
            begin
                sgn_next = sm_reg < peak_reg;
            end
            ST_SM_UPD:
            begin
                sm_next   = pole_upd(peak_reg, prod_reg, sgn_reg);
                x_next    = sm_next;
                zero_next = (sm_next == '0);
                p_next    = 5'd24;
                step_next = '0;
            end
            // leading one search, halving the shift each cycle
            ST_NORM:
            begin
                step_next = step_reg + 3'd1;
                case (step_reg)
                    3'd0:
                    begin
                        if (x_reg[24:9] == '0)
                        begin
                            x_next = x_reg << 16;
                            p_next = p_reg - 5'd16;
                        end
                    end
                    3'd1:
                    begin
                        if (x_reg[24:17] == '0)
                        begin
                            x_next = x_reg << 8;
                            p_next = p_reg - 5'd8;
                        end
                    end
                    3'd2:
                    begin
                        if (x_reg[24:21] == '0)
                        begin
                            x_next = x_reg << 4;
                            p_next = p_reg - 5'd4;
                        end
                    end
                    3'd3:
                    begin
                        if (x_reg[24:23] == '0)
                        begin
                            x_next = x_reg << 2;
                            p_next = p_reg - 5'd2;
                        end
                    end
                    default:
                    begin
                        if (!x_reg[24])
                        begin
                            x_next = x_reg << 1;
                            p_next = p_reg - 5'd1;
                        end
                    end
                endcase
            end
            ST_LOG_NEG:
            begin
                lf        = log2_lut({1'b0, x_reg[23:20]}) + 17'(prod_reg[24:12]);
                negl_next = {5'd24 - p_reg, 16'b0} - 21'(lf);
            end
            // level in dB and distance above the knee start
            ST_LEVEL:
            begin
                mdb_sum = prod_reg[40:0] + 41'h800000;
                mdb     = mdb_sum[40:24];
                if (zero_reg || mdb > 17'd32768)
                begin
                    lvl = -17'sd32768;
                end
                else
                begin
                    lvl = -$signed(mdb);
                end
                over_s = $signed({6'b0, cfg.knee_db}) + 19'(lvl)
                         - 19'(cfg.threshold_db);
                over_next = over_s[18] ? 16'd0 : over_s[15:0];
            end
            ST_T_UPD:
            begin
                t_next = (prod_reg[39:6] > 34'h10000) ? 17'h10000 : prod_reg[22:6];
            end
            ST_AO:
            begin
                ao_next = prod_reg[28:0];
            end
            ST_AT:
            begin
                den_next = 30'h1000000 + prod_reg[29:0];
            end
            // rounded dividend, quotient fits in the low bits
            ST_NUM:
            begin
                n_full   = {1'b0, prod_reg[45:0]} + {18'b0, den_reg[29:1]};
                rem_next = n_full[46:17];
                dl_next  = n_full[16:0];
                x_next   = '0;
            end
            ST_DIV:
            begin
                r2 = {rem_reg, dl_reg[16]};
                if (r2 >= {1'b0, den_reg})
                begin
                    rem_next = 30'(r2 - {1'b0, den_reg});
                    dl_next  = {dl_reg[15:0], 1'b1};
                end
                else
                begin
                    rem_next = r2[29:0];
                    dl_next  = {dl_reg[15:0], 1'b0};
                end
                x_next = x_reg + 25'd1;
            end
            ST_E_UPD:
            begin
                e_sum  = prod_reg[31:0] + 32'd128;
                e_next = e_sum[30:8];
            end
            ST_G_UPD:
            begin
                g_base = pow2_lut({1'b0, e_reg[15:12]}) - 17'(prod_reg[23:12]);
                if (e_reg[22:16] >= 7'd17)
                begin
                    g_next = '0;
                end
                else
                begin
                    g_next = g_base >> e_reg[20:16];
                end
            end
            // round, saturate and restore the sign
            ST_OUT:
            begin
                y_sum = prod_reg[40:0] + 41'd32768;
                y     = y_sum[40:16];
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (smp_reg.neg)
                    begin
                        if (y > 25'h800000)
                        begin
                            y = 25'h800000;
                        end
                        out_next = SAMPLE_BITS'(-y);
                    end
                    else
                    begin
                        if (y > 25'h7FFFFF)
                        begin
                            y = 25'h7FFFFF;
                        end
                        out_next = y[SAMPLE_BITS-1:0];
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // control and envelope state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            peak_reg      <= '0;
            sm_reg        <= '0;
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
            x_reg         <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            peak_reg      <= peak_next;
            sm_reg        <= sm_next;
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
            x_reg         <= x_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        smp_reg  <= smp_next;
        sgn_reg  <= sgn_next;
        p_reg    <= p_next;
        zero_reg <= zero_next;
        negl_reg <= negl_next;
        over_reg <= over_next;
        t_reg    <= t_next;
        ao_reg   <= ao_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dl_reg   <= dl_next;
        e_reg    <= e_next;
        g_reg    <= g_next;
        out_reg  <= out_next;
        if (mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // envelopes stay within unity
    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        peak_reg <= ENV_ONE)
        else $error("peak envelope above unity");

    a_sm_range: assert property (@(posedge clk) disable iff (!rst_n)
        sm_reg <= ENV_ONE)
        else $error("smoothed envelope above unity");

    // partial remainder always below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_DIV |-> rem_reg < den_reg)
        else $error("divider remainder not below divisor");

    // a result beat is only loaded from the final state
    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output loaded outside final state");

endmodule

// ===== rtl/soft_knee_audio_compressor.sv =====
// ----------------------------------------------------------------------------
// soft_knee_audio_compressor
// Feed-forward soft knee compressor with peak detector and attack/release
// smoother, one signed Q1.23 sample in and one out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one sample per beat; out_valid/out_ready carry the
//   compressed sample. The front classifies each sample into a two-entry
//   queue, so new beats are taken while a result waits at the output.
//   Each sample then runs through one shared 30x24 multiplier and a
//   bit-serial divider: the 17-step divider, the 5-step leading one search
//   and the chain of multiplies on the shared multiplier run in turn, and
//   the next sample is popped only once the current one is in the output
//   register.
//   The config port writes one register per cycle with cfg_write high;
//   cfg_index selects detect, attack, release, threshold, knee, knee
//   reciprocal, ratio. Write only while the block is idle.
//   Reset clears both envelopes, empties the queue and loads the default
//   register values. When out_ready is low the result is held in the output
//   register; the queue fills and then in_ready drops.
// ----------------------------------------------------------------------------
module soft_knee_audio_compressor
    import skc_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] out_sample,
    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data
);

    cfg_t cfg_reg, cfg_next;
    logic push, queue_ready, pop, pop_valid;
    smp_t push_data, pop_data;

    // config register file
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_DETECT:     cfg_next.detect_coeff  = cfg_data;
                CFG_ATTACK:     cfg_next.attack_coeff  = cfg_data;
                CFG_RELEASE:    cfg_next.release_coeff = cfg_data;
                CFG_THRESHOLD:  cfg_next.threshold_db  = cfg_data[15:0];
                CFG_KNEE:       cfg_next.knee_db       = cfg_data[12:0];
                CFG_KNEE_RECIP: cfg_next.knee_recip    = cfg_data;
                CFG_RATIO:      cfg_next.ratio         = cfg_data[12:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.detect_coeff  <= 24'd16773721;
            cfg_reg.attack_coeff  <= 24'd16603361;
            cfg_reg.release_coeff <= 24'd16776517;
            cfg_reg.threshold_db  <= -16'sd5120;
            cfg_reg.knee_db       <= 13'd768;
            cfg_reg.knee_recip    <= 24'd5460;
            cfg_reg.ratio         <= 13'd512;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    skc_front u_front (
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_sample   (in_sample),
        .push        (push),
        .push_data   (push_data),
        .queue_ready (queue_ready)
    );

    skc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .push_ready (queue_ready),
        .pop        (pop),
        .pop_data   (pop_data),
        .pop_valid  (pop_valid)
    );

    skc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .pop_valid  (pop_valid),
        .pop_data   (pop_data),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample)
    );

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the soft knee compressor. A built-in fixed point
// predictor tracks both envelopes and the gain computer, and every output beat
// is matched against the oldest predicted sample. The run goes through several
// register settings, including the extremes. Both sides idle at random, and
// there is one long output stall.
// ----------------------------------------------------------------------------
module tb_top
    import skc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 80;

    // compressor gain predictor and store of expected samples
    class comp_scoreboard;
        logic [23:0]        detect_c, attack_c, release_c, knee_rc;
        logic signed [15:0] thresh;
        logic [12:0]        knee, ratio_r;
        longint unsigned    peak_env, smooth_env;
        logic [23:0]        expected_samples[$];
        int                 errors;
        longint unsigned    log2_tab[17] = '{0, 5732, 11136, 16248, 21098, 25711,
            30110, 34312, 38336, 42196, 45904, 49472, 52911, 56229, 59434, 62534,
            65536};
        longint unsigned    pow2_tab[17] = '{65536, 62757, 60097, 57549, 55109,
            52773, 50535, 48393, 46341, 44376, 42495, 40693, 38968, 37316, 35734,
            34219, 32768};

        function void reset_state();
            detect_c   = 24'd16773721;
            attack_c   = 24'd16603361;
            release_c  = 24'd16776517;
            thresh     = -16'sd5120;
            knee       = 13'd768;
            knee_rc    = 24'd5460;
            ratio_r    = 13'd512;
            peak_env   = 0;
            smooth_env = 0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
            case (idx)
                CFG_DETECT:     detect_c = val;
                CFG_ATTACK:     attack_c = val;
                CFG_RELEASE:    release_c = val;
                CFG_THRESHOLD:  thresh = val[15:0];
                CFG_KNEE:       knee = val[12:0];
                CFG_KNEE_RECIP: knee_rc = val;
                CFG_RATIO:      ratio_r = val[12:0];
                default:        ;
            endcase
        endfunction

        function longint unsigned pole(longint unsigned prev, longint unsigned tgt,
                                       logic [23:0] c);
            longint unsigned acc;
            acc = (c * prev + ((64'd1 << 24) - c) * tgt + (64'd1 << 23)) >> 24;
            if (acc > (64'd1 << 24))
                acc = 64'd1 << 24;
            return acc;
        endfunction

        // smoothed envelope to dB, Q8.8
        function int env_to_db(longint unsigned s);
            longint unsigned v, f, idx, fr, lf, nl, mag;
            int p;
            if (s == 0)
                return -32768;
            if (s > (64'd1 << 24))
                s = 64'd1 << 24;
            v = s;
            p = 0;
            while (v > 1)
            begin
                v = v >> 1;
                p++;
            end
            f   = (s << (31 - p)) & 64'h7FFF_FFFF;
            idx = f >> 27;
            fr  = (f >> 15) & 64'hFFF;
            lf  = log2_tab[idx] + (((log2_tab[idx+1] - log2_tab[idx]) * fr) >> 12);
            nl  = longint'(24 - p) * 65536 - lf;
            mag = (nl * 394567 + 8388608) >> 24;
            if (mag > 32768)
                return -32768;
            return -int'(mag);
        endfunction

        function longint unsigned att_to_gain(longint unsigned att);
            longint unsigned e, n, f, idx, fr, g;
            e = (att * 10885 + 128) >> 8;
            n = e >> 16;
            f = e & 64'hFFFF;
            idx = f >> 12;
            fr = f & 64'hFFF;
            if (n >= 17)
                return 0;
            g = pow2_tab[idx] - (((pow2_tab[idx] - pow2_tab[idx+1]) * fr) >> 12);
            return g >> n;
        endfunction

        // accepted input beat: advance the envelopes and predict the output
        function void note_input(logic [23:0] smp);
            logic            neg;
            longint unsigned mag, env, t, a, num, den, att, g, y;
            longint          over;
            int              lvl;
            logic [23:0]     c;
            neg = smp[23];
            mag = neg ? ((64'd1 << 24) - smp) : smp;
            env = mag << 1;
            if (env > (64'd1 << 24))
                env = 64'd1 << 24;
            peak_env = pole(peak_env, env, detect_c);
            c = (smooth_env < peak_env) ? attack_c : release_c;
            smooth_env = pole(smooth_env, peak_env, c);
            lvl  = env_to_db(smooth_env);
            over = longint'(knee) + lvl - longint'(thresh);
            if (over < 0)
                over = 0;
            t = (longint'(knee_rc) * over) >> 6;
            if (t > 65536)
                t = 65536;
            a   = (ratio_r < 256) ? 0 : ratio_r - 256;
            num = a * over * t;
            den = (64'd1 << 24) + a * t;
            att = (num + (den >> 1)) / den;
            g   = att_to_gain(att);
            y   = (mag * g + 32768) >> 16;
            if (neg)
            begin
                if (y > 64'd8388608)
                    y = 64'd8388608;
                expected_samples.push_back(24'((64'd1 << 24) - y));
            end
            else
            begin
                if (y > 64'd8388607)
                    y = 64'd8388607;
                expected_samples.push_back(24'(y));
            end
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_output(logic [23:0] got);
            logic [23:0] want;
            if (expected_samples.size() == 0)
            begin
                report($sformatf("unexpected out_sample %h", got));
                return;
            end
            want = expected_samples.pop_front();
            if (got !== want)
                report($sformatf("out_sample got %h want %h", got, want));
        endtask
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    logic signed [SAMPLE_BITS-1:0] in_sample = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic signed [SAMPLE_BITS-1:0] out_sample;
    logic                          cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]          cfg_index = CFG_DETECT;
    logic [CFG_DATA_W-1:0]         cfg_data = '0;

    comp_scoreboard sb;
    int tx_idle_pct = 8;
    int rx_idle_pct = 46;
    int rx_hold = 0;
    int quiet_cycles = 0;

    soft_knee_audio_compressor u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_sample  (in_sample),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_sample (out_sample),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    // receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        if (rx_hold > 0)
        begin
            out_ready <= 1'b0;
            rx_hold <= rx_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // output beat monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_output(out_sample);
    end

    // watchdog on cycles without any beat
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task send_sample(logic signed [23:0] smp);
        if ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < tx_idle_pct)
                @(posedge clk);
        end
        in_valid  <= 1'b1;
        in_sample <= smp;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_input(smp);
    endtask

    task stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // wait for every expected sample, then let the pipeline settle
    task drain();
        while (sb.expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] idx, logic [23:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
    endtask

    task write_all(logic [23:0] det, logic [23:0] att, logic [23:0] rel,
                   logic [15:0] thr, logic [12:0] kn, logic [23:0] krc,
                   logic [12:0] rat);
        write_reg(CFG_DETECT, det);
        write_reg(CFG_ATTACK, att);
        write_reg(CFG_RELEASE, rel);
        write_reg(CFG_THRESHOLD, {8'd0, thr});
        write_reg(CFG_KNEE, {11'd0, kn});
        write_reg(CFG_KNEE_RECIP, krc);
        write_reg(CFG_RATIO, {11'd0, rat});
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    function logic signed [23:0] random_sample(int bits);
        logic [23:0] m;
        m = 24'($urandom & ((32'd1 << bits) - 1));
        if (bits == 23 && $urandom_range(15) == 0)
            return 24'sh800000;
        return $urandom_range(1) ? -$signed(m) : $signed(m);
    endfunction

    // bursts of loud, mid, quiet and silent passages with random content
    task random_run(int n);
        int sent, burst, bits;
        sent = 0;
        while (sent < n)
        begin
            burst = $urandom_range(10, 60);
            if (burst > n - sent)
                burst = n - sent;
            bits  = ($urandom_range(3) == 0) ? 0 : $urandom_range(23);
            repeat (burst)
            begin
                send_sample(bits == 0 ? 24'sd0 : random_sample(bits));
                sent++;
            end
        end
        stop_sending();
    endtask

    function logic [23:0] random_coeff();
        return 24'(32'hFFFFFF - ($urandom & ((32'd1 << $urandom_range(24)) - 1)));
    endfunction

    initial
    begin
        logic [12:0] kn;
        sb = new();
        sb.reset_state();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults: extremes of the sample field, then a loud burst
        send_sample(24'sd0);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd1);
        send_sample(-24'sd1);
        send_sample(24'sd0);
        repeat (6) send_sample(24'sd8388607);
        repeat (4) send_sample(-24'sd8388608);
        stop_sending();
        drain();

        // instant poles, lowest threshold, hard knee, max ratio: strongest attenuation
        write_all(24'd0, 24'd0, 24'd0, -16'sd24576, 13'd0, 24'hFFFFFF, 13'd5120);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        send_sample(24'sd4096);
        send_sample(24'sd0);
        send_sample(24'sd1);
        stop_sending();
        drain();

        // slowest poles, top threshold, widest knee, no compression
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'sd2560, 13'd5120,
                  24'd0, 13'd256);
        send_sample(24'sd8388607);
        send_sample(-24'sd8388608);
        stop_sending();
        drain();

        // ratio below one, and a write to an index beyond the register list
        write_all(24'd1000, 24'd5000, 24'd90000, -16'sd12000, 13'd256,
                  24'd16384, 13'd128);
        write_reg(CFG_UNUSED, 24'h123456);
        cfg_write <= 1'b0;
        @(posedge clk);
        send_sample(24'sd8388607);
        send_sample(-24'sd6000000);
        send_sample(24'sd0);
        stop_sending();
        drain();

        // random settings and random passages
        for (int ph = 0; ph < 11; ph++)
        begin
            if (ph == 4)
            begin
                tx_idle_pct = 46;
                rx_idle_pct = 8;
            end
            if (ph == 8)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            kn = 13'($urandom_range(5120));
            write_all(random_coeff(), random_coeff(), random_coeff(),
                      16'($signed($urandom_range(27136)) - 24576), kn,
                      $urandom_range(1) ? 24'((64'd1 << 22) / (kn + 1))
                                        : 24'($urandom),
                      13'($urandom_range(256, 5120)));
            if (ph == 2)
                rx_hold = 400;
            random_run(100);
            drain();
        end

        if (sb.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/skc_pkg.sv
rtl/skc_front.sv
rtl/skc_fifo.sv
rtl/skc_back.sv
rtl/soft_knee_audio_compressor.sv
sim/tb_top.sv
